// ===== design/pid_controller_clamped_filtered_defines.svh =====
// assertion macros for the pid controller block
`ifndef PID_CONTROLLER_CLAMPED_FILTERED_DEFINES_SVH
`define PID_CONTROLLER_CLAMPED_FILTERED_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, sampled on clk, off while rst_n is low
`define PIDC_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pid controller check failed");
// next-cycle implication, sampled on clk, off while rst_n is low
`define PIDC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pid controller check failed");
`else
`define PIDC_ASSERT_IMPLY(lbl, ante, cons)
`define PIDC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== design/pidc_pkg.sv =====
// shared widths, codes and types of the pid controller
package pidc_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned WIDE_W    = 48;
  localparam int unsigned ACC_W     = 64;
  localparam int unsigned ALPHA_W   = 16;
  localparam int unsigned LIMIT_W   = 31;
  localparam int unsigned CFG_IDX_W = 3;

  localparam int unsigned PIDC_DEFAULT_DT_US = 10000;
  localparam int unsigned PIDC_TICKS_PER_SEC = 1000000;

  // command codes of an input beat
  localparam logic CMD_COMPUTE = 1'b0;
  localparam logic CMD_RESET   = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P         = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_CLAMP = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_ALPHA    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_CLAMP   = 3'd5;

  // saturation limits of the wide values and of each gain term
  localparam logic signed [ACC_W-1:0] W48_MAX  = 64'sd140737488355327;
  localparam logic signed [ACC_W-1:0] TERM_MAX = 64'sd2305843009213693952;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_ID,
    ST_DIV1_LD,
    ST_DIV1_RUN,
    ST_INT_UPD,
    ST_DIV2_LD,
    ST_DIV2_RUN,
    ST_RAW_UPD,
    ST_EMA,
    ST_EMA_FIN,
    ST_GAIN,
    ST_OUT
  } state_t;

endpackage

// ===== design/pidc_ifs.sv =====
// valid/ready channel interfaces of the pid controller

// input channel: one compute or reset beat
interface pidc_in_if;
  import pidc_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     cmd;
  logic signed [DATA_W-1:0] target;
  logic signed [DATA_W-1:0] measured;
  logic        [DATA_W-1:0] now_us;
  modport source (output valid, cmd, target, measured, now_us, input ready);
  modport sink (input valid, cmd, target, measured, now_us, output ready);
endinterface

// result channel: one drive value per compute beat
interface pidc_out_if;
  import pidc_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] drive;
  logic                     clamped;
  modport source (output valid, drive, clamped, input ready);
  modport sink (input valid, drive, clamped, output ready);
endinterface

// configuration write channel
interface pidc_cfg_if;
  import pidc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DATA_W-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== design/pid_controller_clamped_filtered.sv =====
// fixed-point pid controller with integral clamp and filtered derivative
//
// Q16.16 pid step with microsecond timestamps. A compute beat holds the input
// not ready from acceptance until its result is offered (a reset beat gives no
// result and leaves the input ready). The step is sequenced over one shared
// 33x33 multiplier, issuing at most one product per cycle for the twelve
// products of a step, and over a shared restoring divider retiring two quotient
// bits a cycle for each of the two divisions (integral increment by
// TICKS_PER_SEC, derivative by dt). The result sits in an output register, so
// a new beat is accepted while the previous result waits. Configuration writes
// are always taken and must only be issued while the block is idle.
module pid_controller_clamped_filtered #(
  parameter int unsigned DEFAULT_DT_US = pidc_pkg::PIDC_DEFAULT_DT_US,
  parameter int unsigned TICKS_PER_SEC = pidc_pkg::PIDC_TICKS_PER_SEC
) (
  input logic        clk,
  input logic        rst_n,
  pidc_cfg_if.sink   cfg_ch,
  pidc_in_if.sink    in_ch,
  pidc_out_if.source out_ch
);
  import pidc_pkg::*;

  `include "pid_controller_clamped_filtered_defines.svh"

  localparam int unsigned DIV_STEPS = ACC_W / 2;
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_STEPS - 1);
  localparam logic [LIMIT_W-1:0] DT_DEFAULT = LIMIT_W'(DEFAULT_DT_US);
  localparam logic [LIMIT_W-1:0] TICKS_DEN  = LIMIT_W'(TICKS_PER_SEC);

  // symmetric saturation
  function automatic logic signed [ACC_W-1:0] sat64(input logic signed [ACC_W-1:0] v,
                                                    input logic signed [ACC_W-1:0] lim);
    logic signed [ACC_W-1:0] r;
    if (v > lim) r = lim;
    else if (v < -lim) r = -lim;
    else r = v;
    return r;
  endfunction

  // configuration registers
  logic signed [DATA_W-1:0]  gain_p_r, gain_i_r, gain_d_r;
  logic        [LIMIT_W-1:0] integral_clamp_r, output_clamp_r;
  logic        [ALPHA_W-1:0] deriv_alpha_r;

  // sequencer and datapath registers
  state_t                   state_r, state_nxt;
  logic [3:0]               step_r, step_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic signed [DATA_W-1:0] err_r, err_nxt;
  logic [LIMIT_W-1:0]       dt_r, dt_nxt;
  logic [DATA_W-1:0]        now_r, now_nxt;
  logic signed [ACC_W-1:0]  prod_r;
  logic [LIMIT_W-1:0]       rem_r, rem_nxt;
  logic [ACC_W-1:0]         quo_r, quo_nxt;
  logic [LIMIT_W-1:0]       den_r, den_nxt;
  logic                     neg_r, neg_nxt;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic signed [ACC_W-1:0]  term_r, term_nxt;
  logic signed [WIDE_W-1:0] raw_r, raw_nxt;

  // controller state
  logic signed [WIDE_W-1:0] integ_r, integ_nxt;
  logic signed [DATA_W-1:0] last_err_r, last_err_nxt;
  logic signed [WIDE_W-1:0] filt_r, filt_nxt;
  logic [DATA_W-1:0]        last_stamp_r, last_stamp_nxt;

  // output register
  logic                     out_valid_r, out_valid_nxt;
  logic signed [DATA_W-1:0] out_drive_r, out_drive_nxt;
  logic                     out_clamped_r, out_clamped_nxt;

  // shared multiplier
  logic                        mul_en;
  logic signed [DATA_W:0]      mul_a, mul_b;
  logic signed [2*DATA_W+1:0]  mul_p;

  // shared divider step and helpers
  logic [LIMIT_W-1:0]       div_rem;
  logic [ACC_W-1:0]         div_quo;
  logic [DATA_W-1:0]        div_sh;
  logic signed [ACC_W-1:0]  quo_s;
  logic [ACC_W-1:0]         prod_mag;
  logic signed [DATA_W:0]   in_diff, err_diff;
  logic [DATA_W-1:0]        stamp_diff;
  logic [ALPHA_W:0]         beta;
  logic [1:0]               grp;
  logic                     is_hi, is_lo, is_add, is_sum;
  logic signed [WIDE_W-1:0] gval;
  logic signed [DATA_W-1:0] gsel;
  logic signed [ACC_W-1:0]  ocl, drive64, int_lim, int_sum;
  logic                     in_fire, cfg_fire;

  assign in_ch.ready   = rst_n && (state_r == ST_IDLE);
  assign cfg_ch.ready  = rst_n;
  assign in_fire       = in_ch.valid && in_ch.ready;
  assign cfg_fire      = cfg_ch.valid && cfg_ch.ready;
  assign out_ch.valid   = out_valid_r;
  assign out_ch.drive   = out_drive_r;
  assign out_ch.clamped = out_clamped_r;

  // configuration writes, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r         <= '0;
      gain_i_r         <= '0;
      gain_d_r         <= '0;
      integral_clamp_r <= '0;
      deriv_alpha_r    <= '0;
      output_clamp_r   <= '0;
    end else if (cfg_fire) begin
      unique case (cfg_ch.index)
        REG_GAIN_P:         gain_p_r         <= $signed(cfg_ch.data);
        REG_GAIN_I:         gain_i_r         <= $signed(cfg_ch.data);
        REG_GAIN_D:         gain_d_r         <= $signed(cfg_ch.data);
        REG_INTEGRAL_CLAMP: integral_clamp_r <= cfg_ch.data[LIMIT_W-1:0];
        REG_DERIV_ALPHA:    deriv_alpha_r    <= cfg_ch.data[ALPHA_W-1:0];
        REG_OUTPUT_CLAMP:   output_clamp_r   <= cfg_ch.data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // two restoring division steps per cycle
  always_comb begin
    div_rem = rem_r;
    div_quo = quo_r;
    div_sh  = '0;
    for (int k = 0; k < 2; k++) begin
      div_sh = {div_rem, div_quo[ACC_W-1]};
      if (div_sh >= {1'b0, den_r}) begin
        div_rem = LIMIT_W'(div_sh - {1'b0, den_r});
        div_quo = {div_quo[ACC_W-2:0], 1'b1};
      end else begin
        div_rem = div_sh[LIMIT_W-1:0];
        div_quo = {div_quo[ACC_W-2:0], 1'b0};
      end
    end
  end

  assign quo_s    = neg_r ? -$signed(quo_r) : $signed(quo_r);
  assign prod_mag = prod_r[ACC_W-1] ? ACC_W'(-prod_r) : ACC_W'(prod_r);
  assign in_diff  = {in_ch.target[DATA_W-1], in_ch.target}
                  - {in_ch.measured[DATA_W-1], in_ch.measured};
  assign err_diff = {err_r[DATA_W-1], err_r} - {last_err_r[DATA_W-1], last_err_r};
  assign stamp_diff = in_ch.now_us - last_stamp_r;
  assign beta     = (ALPHA_W+1)'(1 << ALPHA_W) - {1'b0, deriv_alpha_r};
  assign int_sum  = {{(ACC_W-WIDE_W){integ_r[WIDE_W-1]}}, integ_r} + quo_s;
  assign int_lim  = (integral_clamp_r != '0) ? $signed({33'b0, integral_clamp_r}) : W48_MAX;
  assign ocl      = $signed({33'b0, output_clamp_r});

  // gain micro-steps: hi product, lo product, merge, then saturate and sum
  always_comb begin
    priority if (step_r < 4'd3) grp = 2'd0;
    else if (step_r < 4'd6) grp = 2'd1;
    else grp = 2'd2;
    is_hi  = (step_r == 4'd0) || (step_r == 4'd3) || (step_r == 4'd6);
    is_lo  = (step_r == 4'd1) || (step_r == 4'd4) || (step_r == 4'd7);
    is_add = (step_r == 4'd2) || (step_r == 4'd5) || (step_r == 4'd8);
    is_sum = (step_r == 4'd3) || (step_r == 4'd6) || (step_r == 4'd9);
    unique case (grp)
      2'd0: begin
        gsel = gain_p_r;
        gval = {{(WIDE_W-DATA_W){err_r[DATA_W-1]}}, err_r};
      end
      2'd1: begin
        gsel = gain_i_r;
        gval = integ_r;
      end
      default: begin
        gsel = gain_d_r;
        gval = filt_r;
      end
    endcase
  end

  // output limiting
  always_comb begin
    if (output_clamp_r != '0) drive64 = sat64(acc_r, ocl);
    else if (acc_r > 64'sd2147483647) drive64 = 64'sd2147483647;
    else if (acc_r < -64'sd2147483648) drive64 = -64'sd2147483648;
    else drive64 = acc_r;
  end

  // shared multiplier with registered product
  assign mul_p = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (mul_en) prod_r <= $signed(mul_p[ACC_W-1:0]);
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_valid_r  <= 1'b0;
      integ_r      <= '0;
      last_err_r   <= '0;
      filt_r       <= '0;
      last_stamp_r <= '0;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      integ_r      <= integ_nxt;
      last_err_r   <= last_err_nxt;
      filt_r       <= filt_nxt;
      last_stamp_r <= last_stamp_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    step_r        <= step_nxt;
    cnt_r         <= cnt_nxt;
    err_r         <= err_nxt;
    dt_r          <= dt_nxt;
    now_r         <= now_nxt;
    rem_r         <= rem_nxt;
    quo_r         <= quo_nxt;
    den_r         <= den_nxt;
    neg_r         <= neg_nxt;
    acc_r         <= acc_nxt;
    term_r        <= term_nxt;
    raw_r         <= raw_nxt;
    out_drive_r   <= out_drive_nxt;
    out_clamped_r <= out_clamped_nxt;
  end

  // sequencer: next state, operand selection and register updates
  always_comb begin
    state_nxt       = state_r;
    step_nxt        = step_r;
    cnt_nxt         = cnt_r;
    err_nxt         = err_r;
    dt_nxt          = dt_r;
    now_nxt         = now_r;
    rem_nxt         = rem_r;
    quo_nxt         = quo_r;
    den_nxt         = den_r;
    neg_nxt         = neg_r;
    acc_nxt         = acc_r;
    term_nxt        = term_r;
    raw_nxt         = raw_r;
    integ_nxt       = integ_r;
    last_err_nxt    = last_err_r;
    filt_nxt        = filt_r;
    last_stamp_nxt  = last_stamp_r;
    out_valid_nxt   = out_valid_r && !out_ch.ready;
    out_drive_nxt   = out_drive_r;
    out_clamped_nxt = out_clamped_r;
    mul_en          = 1'b0;
    mul_a           = '0;
    mul_b           = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_ch.cmd == CMD_RESET) begin
            integ_nxt      = '0;
            last_err_nxt   = '0;
            filt_nxt       = '0;
            last_stamp_nxt = in_ch.now_us;
          end else begin
            // error saturated to 32 bits, dt replaced when not positive
            // a difference of exactly the minimum lands one above it
            if (in_diff[DATA_W] != in_diff[DATA_W-1])
              err_nxt = in_diff[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}}
                                        : {1'b0, {(DATA_W-1){1'b1}}};
            else if (in_diff == {2'b11, {(DATA_W-1){1'b0}}})
              err_nxt = {1'b1, {(DATA_W-2){1'b0}}, 1'b1};
            else
              err_nxt = in_diff[DATA_W-1:0];
            if (stamp_diff[DATA_W-1] || (stamp_diff == '0)) dt_nxt = DT_DEFAULT;
            else dt_nxt = stamp_diff[LIMIT_W-1:0];
            now_nxt   = in_ch.now_us;
            state_nxt = ST_MUL_ID;
          end
        end
      end
      ST_MUL_ID: begin
        mul_en    = 1'b1;
        mul_a     = {err_r[DATA_W-1], err_r};
        mul_b     = {2'b0, dt_r};
        state_nxt = ST_DIV1_LD;
      end
      ST_DIV1_LD: begin
        // divide err*dt by the tick rate, meanwhile form diff*ticks
        rem_nxt   = '0;
        quo_nxt   = prod_mag;
        neg_nxt   = prod_r[ACC_W-1];
        den_nxt   = TICKS_DEN;
        cnt_nxt   = '0;
        mul_en    = 1'b1;
        mul_a     = err_diff;
        mul_b     = {2'b0, TICKS_DEN};
        state_nxt = ST_DIV1_RUN;
      end
      ST_DIV1_RUN: begin
        rem_nxt = div_rem;
        quo_nxt = div_quo;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == DIV_LAST) state_nxt = ST_INT_UPD;
      end
      ST_INT_UPD: begin
        integ_nxt = WIDE_W'(sat64(int_sum, int_lim));
        state_nxt = ST_DIV2_LD;
      end
      ST_DIV2_LD: begin
        rem_nxt   = '0;
        quo_nxt   = prod_mag;
        neg_nxt   = prod_r[ACC_W-1];
        den_nxt   = dt_r;
        cnt_nxt   = '0;
        state_nxt = ST_DIV2_RUN;
      end
      ST_DIV2_RUN: begin
        rem_nxt = div_rem;
        quo_nxt = div_quo;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == DIV_LAST) state_nxt = ST_RAW_UPD;
      end
      ST_RAW_UPD: begin
        raw_nxt  = WIDE_W'(sat64(quo_s, W48_MAX));
        step_nxt = '0;
        if (deriv_alpha_r == '0) begin
          filt_nxt  = WIDE_W'(sat64(quo_s, W48_MAX));
          acc_nxt   = '0;
          state_nxt = ST_GAIN;
        end else begin
          state_nxt = ST_EMA;
        end
      end
      ST_EMA: begin
        // alpha*filt + beta*raw, each split in a signed high and unsigned low half
        step_nxt = step_r + 1'b1;
        mul_en   = (step_r < 4'd4);
        unique case (step_r)
          4'd0: begin
            mul_a = {17'b0, deriv_alpha_r};
            mul_b = {{9{filt_r[WIDE_W-1]}}, filt_r[WIDE_W-1:24]};
          end
          4'd1: begin
            mul_a   = {17'b0, deriv_alpha_r};
            mul_b   = {9'b0, filt_r[23:0]};
            acc_nxt = prod_r <<< 24;
          end
          4'd2: begin
            mul_a   = {16'b0, beta};
            mul_b   = {{9{raw_r[WIDE_W-1]}}, raw_r[WIDE_W-1:24]};
            acc_nxt = acc_r + prod_r;
          end
          4'd3: begin
            mul_a   = {16'b0, beta};
            mul_b   = {9'b0, raw_r[23:0]};
            acc_nxt = acc_r + (prod_r <<< 24);
          end
          default: begin
            acc_nxt   = acc_r + prod_r;
            state_nxt = ST_EMA_FIN;
          end
        endcase
      end
      ST_EMA_FIN: begin
        filt_nxt  = WIDE_W'(sat64(acc_r >>> 16, W48_MAX));
        acc_nxt   = '0;
        step_nxt  = '0;
        state_nxt = ST_GAIN;
      end
      ST_GAIN: begin
        // floor(gain*v/2^16) = (gain*vh)<<8 + floor(gain*vl/2^16)
        step_nxt = step_r + 1'b1;
        mul_en   = is_hi || is_lo;
        mul_a    = {gsel[DATA_W-1], gsel};
        if (is_hi) mul_b = {{9{gval[WIDE_W-1]}}, gval[WIDE_W-1:24]};
        else mul_b = {9'b0, gval[23:0]};
        if (is_lo) term_nxt = prod_r <<< 8;
        if (is_add) term_nxt = term_r + (prod_r >>> 16);
        if (is_sum) acc_nxt = acc_r + sat64(term_r, TERM_MAX);
        if (step_r == 4'd9) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt   = 1'b1;
          out_drive_nxt   = drive64[DATA_W-1:0];
          out_clamped_nxt = (drive64 != acc_r);
          last_err_nxt    = err_r;
          last_stamp_nxt  = now_r;
          state_nxt       = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // checks on the sequencer
  `PIDC_ASSERT_NEXT(a_reset_beat_no_work, in_fire && (in_ch.cmd == CMD_RESET), state_r == ST_IDLE)
  `PIDC_ASSERT_NEXT(a_compute_beat_busy, in_fire && (in_ch.cmd == CMD_COMPUTE), !in_ch.ready)
  `PIDC_ASSERT_IMPLY(a_result_from_out_state, $rose(out_valid_r), $past(state_r == ST_OUT))
  `PIDC_ASSERT_NEXT(a_div_ends, (state_r == ST_DIV1_RUN) && (cnt_r == DIV_LAST), state_r == ST_INT_UPD)

endmodule

// ===== sim/pid_controller_clamped_filtered_test.sv =====
// self-checking testbench of the pid controller with clamps and derivative filter
module pid_controller_clamped_filtered_test;
  import pidc_pkg::*;

  // codes beyond the six registers, written once to show they are ignored
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_7 = 3'd7;

  localparam longint I32_MAX     = 64'sd2147483647;
  localparam longint I32_MIN     = -64'sd2147483648;
  localparam longint DT_FALLBACK = longint'(PIDC_DEFAULT_DT_US);
  localparam longint TICKS       = longint'(PIDC_TICKS_PER_SEC);
  localparam int     DRAIN_CYCLES = 120;
  localparam int     HOLD_CYCLES  = 2000;

  typedef struct packed {
    logic                     cmd;
    logic signed [DATA_W-1:0] target;
    logic signed [DATA_W-1:0] measured;
    logic        [DATA_W-1:0] now_us;
  } pid_beat_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] drive;
    logic                     clamped;
  } drive_result_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // locally held channel drive, known from time zero
  logic                     in_valid    = 1'b0;
  logic                     in_cmd      = CMD_COMPUTE;
  logic signed [DATA_W-1:0] in_target   = '0;
  logic signed [DATA_W-1:0] in_measured = '0;
  logic        [DATA_W-1:0] in_now      = '0;
  logic                     out_ready   = 1'b0;
  logic                     cfg_valid   = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index   = '0;
  logic [DATA_W-1:0]        cfg_data    = '0;

  pidc_in_if  in_ch ();
  pidc_out_if out_ch ();
  pidc_cfg_if cfg_ch ();

  assign in_ch.valid    = in_valid;
  assign in_ch.cmd      = in_cmd;
  assign in_ch.target   = in_target;
  assign in_ch.measured = in_measured;
  assign in_ch.now_us   = in_now;
  assign out_ch.ready   = out_ready;
  assign cfg_ch.valid   = cfg_valid;
  assign cfg_ch.index   = cfg_index;
  assign cfg_ch.data    = cfg_data;

  pid_controller_clamped_filtered dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  pid_beat_t     steps_queued [$];
  drive_result_t drives_due [$];
  int            fail_count = 0;

  // predicted controller registers and dynamic state
  longint            kp = 0, ki = 0, kd = 0;
  longint            int_lim = 0, alpha = 0, out_lim = 0;
  longint            integ = 0, prev_err = 0, deriv_f = 0;
  logic [DATA_W-1:0] stamp = '0;

  // stimulus bookkeeping
  logic        [DATA_W-1:0] sim_us   = '0;
  logic signed [DATA_W-1:0] setpoint = '0;
  logic                     hold_arm = 1'b0;

  function automatic longint clip(input longint v, input longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // exact q16.16 product, floored, saturated to the term limit
  function automatic longint gain_term(input longint g, input longint v);
    logic signed [95:0] prod;
    prod = g;
    prod = (prod * v) >>> 16;
    if (prod > TERM_MAX) return TERM_MAX;
    if (prod < -TERM_MAX) return -TERM_MAX;
    return longint'(prod);
  endfunction

  // one controller step; returns 1 when the beat yields a drive value
  function automatic bit pid_step(input pid_beat_t b, output drive_result_t r);
    longint            diff, err, dt, raw, total, lim_out;
    logic [DATA_W-1:0] gap_us;
    r = '0;
    if (b.cmd == CMD_RESET) begin
      integ    = 0;
      prev_err = 0;
      deriv_f  = 0;
      stamp    = b.now_us;
      return 1'b0;
    end
    diff = longint'($signed(b.target)) - longint'($signed(b.measured));
    // a difference of exactly the minimum lands one above it
    if (diff > I32_MAX) err = I32_MAX;
    else if (diff < I32_MIN) err = I32_MIN;
    else if (diff == I32_MIN) err = I32_MIN + 1;
    else err = diff;
    // elapsed time, non-positive falls back to the default step
    gap_us = b.now_us - stamp;
    dt = longint'($signed(gap_us));
    if (dt <= 0) dt = DT_FALLBACK;
    // integral with wide saturation, then optional clamp
    integ = clip(integ + (err * dt) / TICKS, W48_MAX);
    if (int_lim != 0) integ = clip(integ, int_lim);
    // derivative and its ema
    raw = clip(((err - prev_err) * TICKS) / dt, W48_MAX);
    if (alpha != 0) deriv_f = (alpha * deriv_f + (64'sd65536 - alpha) * raw) >>> 16;
    else deriv_f = raw;
    deriv_f  = clip(deriv_f, W48_MAX);
    prev_err = err;
    stamp    = b.now_us;
    total = gain_term(kp, err) + gain_term(ki, integ) + gain_term(kd, deriv_f);
    if (out_lim != 0) lim_out = clip(total, out_lim);
    else if (total > I32_MAX) lim_out = I32_MAX;
    else if (total < I32_MIN) lim_out = I32_MIN;
    else lim_out = total;
    r.drive   = lim_out[DATA_W-1:0];
    r.clamped = (lim_out != total);
    return 1'b1;
  endfunction

  function automatic int pick_gap();
    if ($urandom_range(0, 9) == 0) return $urandom_range(20, 80);
    return $urandom_range(1, 4);
  endfunction

  function automatic logic [DATA_W-1:0] pick_limit();
    case ($urandom_range(0, 5))
      0, 1:    return '0;
      2:       return $urandom;
      default: return $urandom_range(1, 32'h0020_0000);
    endcase
  endfunction

  // input driver: offers queued beats with random gaps after some beats
  int        tx_wait = 0;
  int        tx_age  = 0;
  bit        tx_calm = 1'b0;
  pid_beat_t tx_beat;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ch.ready) begin
      if (tx_wait != 0) begin
        tx_wait = tx_wait - 1;
        in_valid <= 1'b0;
      end else if (steps_queued.size() != 0) begin
        tx_beat = steps_queued.pop_front();
        in_valid    <= 1'b1;
        in_cmd      <= tx_beat.cmd;
        in_target   <= tx_beat.target;
        in_measured <= tx_beat.measured;
        in_now      <= tx_beat.now_us;
        if (!tx_calm && $urandom_range(0, 99) < 30) tx_wait = pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
    tx_age = tx_age + 1;
    if (tx_age == 256) begin
      tx_age  = 0;
      tx_calm = ($urandom_range(0, 3) == 0);
    end
  end

  // result receiver: random stalls, one long hold-off when armed
  int rx_wait    = 0;
  int rx_hold    = 0;
  int rx_age     = 0;
  bit rx_calm    = 1'b0;
  bit hold_taken = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (rx_hold != 0) begin
      rx_hold = rx_hold - 1;
      out_ready <= 1'b0;
    end else if (hold_arm && !hold_taken) begin
      hold_taken = 1'b1;
      rx_hold    = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (rx_wait != 0) begin
      rx_wait = rx_wait - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (!rx_calm && $urandom_range(0, 99) < 25) rx_wait = pick_gap();
    end
    rx_age = rx_age + 1;
    if (rx_age == 256) begin
      rx_age  = 0;
      rx_calm = ($urandom_range(0, 3) == 0);
    end
  end

  // monitor: register writes, result checks, prediction of accepted beats
  drive_result_t due, fresh;
  pid_beat_t     seen;

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_GAIN_P:         kp = longint'($signed(cfg_ch.data));
          REG_GAIN_I:         ki = longint'($signed(cfg_ch.data));
          REG_GAIN_D:         kd = longint'($signed(cfg_ch.data));
          REG_INTEGRAL_CLAMP: int_lim = longint'(cfg_ch.data[LIMIT_W-1:0]);
          REG_DERIV_ALPHA:    alpha = longint'(cfg_ch.data[ALPHA_W-1:0]);
          REG_OUTPUT_CLAMP:   out_lim = longint'(cfg_ch.data[LIMIT_W-1:0]);
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        if (drives_due.size() == 0) begin
          $display("%0t: result beat with nothing expected, drive %0d clamped %0b",
                   $time, $signed(out_ch.drive), out_ch.clamped);
          fail_count++;
        end else begin
          due = drives_due.pop_front();
          if (out_ch.drive !== due.drive) begin
            $display("%0t: drive expected %0d actual %0d",
                     $time, $signed(due.drive), $signed(out_ch.drive));
            fail_count++;
          end
          if (out_ch.clamped !== due.clamped) begin
            $display("%0t: clamped expected %0b actual %0b",
                     $time, due.clamped, out_ch.clamped);
            fail_count++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        seen = '{cmd: in_ch.cmd, target: in_ch.target, measured: in_ch.measured,
                 now_us: in_ch.now_us};
        if (pid_step(seen, fresh)) drives_due.push_back(fresh);
      end
    end
  end

  task automatic add_beat(input logic c, input logic [DATA_W-1:0] t,
                          input logic [DATA_W-1:0] m, input logic [DATA_W-1:0] now);
    pid_beat_t b;
    b = '{cmd: c, target: t, measured: m, now_us: now};
    steps_queued.push_back(b);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_settings(input logic [DATA_W-1:0] p, i, d, ic, a, oc);
    write_reg(REG_GAIN_P, p);
    write_reg(REG_GAIN_I, i);
    write_reg(REG_GAIN_D, d);
    write_reg(REG_INTEGRAL_CLAMP, ic);
    write_reg(REG_DERIV_ALPHA, a);
    write_reg(REG_OUTPUT_CLAMP, oc);
  endtask

  task automatic load_random_settings();
    logic [DATA_W-1:0] g [3];
    for (int k = 0; k < 3; k++) begin
      if ($urandom_range(0, 3) == 0) g[k] = $urandom;
      else g[k] = $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
    end
    load_settings(g[0], g[1], g[2], pick_limit(),
                  ($urandom_range(0, 2) == 0) ? 32'd0 : $urandom, pick_limit());
  endtask

  // wait until every beat is out and every drive is back, then let the block settle
  task automatic settle();
    while (steps_queued.size() != 0 || in_valid || drives_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // long run of full-scale error with near-maximal time steps drives the integral wide
  task automatic queue_windup(input int count);
    bit neg;
    neg = $urandom_range(0, 1);
    for (int n = 0; n < count; n++) begin
      sim_us = sim_us + 32'h7FFF_0000;
      if (neg) add_beat(CMD_COMPUTE, 32'h8000_0000, 32'h7FFF_FFFF, sim_us);
      else add_beat(CMD_COMPUTE, 32'h7FFF_FFFF, 32'h8000_0000, sim_us);
    end
  endtask

  // mostly a tracking loop around a setpoint, with resets, noise and windup runs
  task automatic queue_random_steps(input int count);
    int                added, roll;
    logic [DATA_W-1:0] noise, step;
    added = 0;
    while (added < count) begin
      roll = $urandom_range(0, 99);
      if (roll == 0) begin
        queue_windup(36);
        added += 36;
      end else if (roll < 9) begin
        sim_us = sim_us + $urandom_range(0, 20000);
        add_beat(CMD_RESET, $urandom, $urandom, sim_us);
        added++;
      end else if (roll < 22) begin
        sim_us = $urandom;
        add_beat(CMD_COMPUTE, $urandom, $urandom, sim_us);
        added++;
      end else begin
        if (roll < 27) setpoint = $urandom_range(0, 32'h00C8_0000) - 32'h0064_0000;
        case ($urandom_range(0, 9))
          0:       step = '0;
          1:       step = $urandom_range(1, 50);
          default: step = $urandom_range(200, 20000);
        endcase
        sim_us = sim_us + step;
        noise  = $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
        add_beat(CMD_COMPUTE, setpoint, setpoint + noise, sim_us);
        added++;
      end
    end
  endtask

  // run limit
  initial begin
    #20000000;
    $display("Regression FAIL");
    $finish;
  end

  // phases of settings and stimulus
  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // plain gains, no clamps, no filter: field extremes and timing corners
    load_settings(32'h0001_0000, 32'h0000_8000, 32'd655, 32'd0, 32'd0, 32'd0);
    add_beat(CMD_RESET,   32'h0000_0000, 32'h0000_0000, 32'd1000);
    add_beat(CMD_COMPUTE, 32'h0000_0000, 32'h0000_0000, 32'd2000);
    add_beat(CMD_COMPUTE, 32'h0001_0000, 32'h0000_0000, 32'd3000);
    add_beat(CMD_COMPUTE, 32'h7FFF_FFFF, 32'h8000_0000, 32'd4000);
    add_beat(CMD_COMPUTE, 32'h8000_0000, 32'h7FFF_FFFF, 32'd5000);
    add_beat(CMD_COMPUTE, 32'h8000_0000, 32'h0000_0000, 32'd6000);
    add_beat(CMD_COMPUTE, 32'h0000_0000, 32'h8000_0000, 32'd7000);
    // same timestamp, then a timestamp going backwards
    add_beat(CMD_COMPUTE, 32'h0001_0000, 32'h0000_8000, 32'd7000);
    add_beat(CMD_COMPUTE, 32'h0001_0000, 32'h0000_8000, 32'd6500);
    // largest positive step, then a step reading as the most negative
    add_beat(CMD_COMPUTE, 32'h0000_0000, 32'h0001_0000, 32'h8000_1963);
    add_beat(CMD_COMPUTE, 32'h0003_0000, 32'h0001_0000, 32'h0000_1963);
    // reset just before the counter wraps, steps across the wrap
    add_beat(CMD_RESET,   32'h1234_5678, 32'h8765_4321, 32'hFFFF_FF00);
    add_beat(CMD_COMPUTE, 32'h0002_0000, 32'h0000_0000, 32'h0000_0100);
    add_beat(CMD_COMPUTE, 32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0101);
    add_beat(CMD_COMPUTE, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0102);
    add_beat(CMD_COMPUTE, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
    add_beat(CMD_RESET,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);
    add_beat(CMD_COMPUTE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
    settle();

    // largest gains and limits, heaviest filter
    load_settings(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  32'h0000_FFFF, 32'h7FFF_FFFF);
    add_beat(CMD_RESET,   32'h0000_0000, 32'h0000_0000, 32'd100);
    add_beat(CMD_COMPUTE, 32'h7FFF_FFFF, 32'h8000_0000, 32'd101);
    add_beat(CMD_COMPUTE, 32'h8000_0000, 32'h7FFF_FFFF, 32'd102);
    sim_us   = 32'd102;
    setpoint = 32'h0010_0000;
    queue_random_steps(110);
    settle();

    // opposite gain signs, no integral clamp, lightest filter, spare indexes
    load_settings(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 32'h0000_0001, 32'd0);
    write_reg(IDX_SPARE_6, $urandom);
    write_reg(IDX_SPARE_7, $urandom);
    sim_us = 32'hFFFF_F000;
    queue_windup(36);
    queue_random_steps(100);
    settle();

    // tightest limits under a long receiver hold-off
    load_settings(32'h0002_0000, 32'h0000_4000, 32'h0000_0800, 32'd1, 32'h0000_8000, 32'd1);
    hold_arm <= 1'b1;
    sim_us   = $urandom;
    queue_random_steps(140);
    settle();

    // all registers back at their reset values
    load_settings(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    queue_random_steps(50);
    settle();

    // random settings
    for (int ph = 0; ph < 5; ph++) begin
      load_random_settings();
      sim_us   = $urandom;
      setpoint = $urandom_range(0, 32'h00C8_0000) - 32'h0064_0000;
      queue_random_steps(170);
      settle();
    end

    if (fail_count == 0 && drives_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
